>>> rtl/core/crzt_pkg.sv
// ============================================================================
// crzt_pkg: shared types and constants for the camera rotate/zoom transform
// Item structs, register indexes, sine/cosine unit states and CORDIC tables.
// ============================================================================
`default_nettype none

package crzt_pkg;

    // Fixed field widths
    localparam int COORD_W    = 24;
    localparam int ZOOM_W     = 24;
    localparam int ANGLE_W    = 17;
    localparam int VIEW_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // One input item and one result item
    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] in_x;
        logic signed [COORD_W-1:0] in_y;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      saturated;
    } result_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZOOM     = 3'd0,
        REG_ANGLE    = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_VIEW_W   = 3'd4,
        REG_VIEW_H   = 3'd5
    } reg_index_t;

    // Sine/cosine unit states
    typedef enum logic [2:0] {
        TRIG_IDLE,
        TRIG_LOAD,
        TRIG_REDUCE,
        TRIG_ROTATE,
        TRIG_FINISH
    } trig_state_t;

    // Angle handling: 1/128 degree units
    localparam logic signed [ANGLE_W-1:0] FULL_TURN    = 17'sd46080;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 17'sd11520;
    localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 17'sd23040;
    localparam logic signed [ANGLE_W-1:0] THREE_QUARTER_TURN = 17'sd34560;

    // CORDIC: Q.30 vectors, angle in 2^-16 degree
    localparam int CORDIC_STEPS = 18;
    localparam int STEP_W       = 5;
    localparam int CV_W         = 34;
    localparam int CZ_W         = 25;
    localparam int TRIG_W       = 18;
    localparam logic [STEP_W-1:0]       LAST_STEP = 5'd17;
    localparam logic signed [CV_W-1:0] CORDIC_X0 = 34'sd652032874;

    // Inverse path clamp and lifted offset width
    localparam logic [63:0] INV_LIMIT = 64'h0000_2000_0000_0000;
    localparam int LIFT_W = 47;

    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;

    // arctan(2^-i) in 2^-16 degree
    function automatic logic signed [CZ_W-1:0] atan_step(input logic [STEP_W-1:0] idx);
        logic signed [CZ_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 25'sd2949120;
                5'd1:    val = 25'sd1740967;
                5'd2:    val = 25'sd919879;
                5'd3:    val = 25'sd466945;
                5'd4:    val = 25'sd234379;
                5'd5:    val = 25'sd117305;
                5'd6:    val = 25'sd58666;
                5'd7:    val = 25'sd29335;
                5'd8:    val = 25'sd14668;
                5'd9:    val = 25'sd7334;
                5'd10:   val = 25'sd3667;
                5'd11:   val = 25'sd1833;
                5'd12:   val = 25'sd917;
                5'd13:   val = 25'sd458;
                5'd14:   val = 25'sd229;
                5'd15:   val = 25'sd115;
                5'd16:   val = 25'sd57;
                5'd17:   val = 25'sd29;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/camera_rotate_zoom_transform.sv
// ============================================================================
// camera_rotate_zoom_transform: pipelined 2D rotate/zoom/translate of points
// Maps canvas points to the view (mode 0) or view points back (mode 1).
// ============================================================================
// Usage:
//   point channel  : point_valid / point_stall / point (mode, in_x, in_y).
//   result channel : result_valid / result_stall / result (out_x, out_y,
//                    saturated). One result per point, in order.
//   config port    : cfg_we / cfg_index / cfg_data, written while idle.
// The bit-per-stage zoom divider, NUM_W = DIFF_W + ZOOM_FRAC_BITS, sets the depth.
// Throughput: one point per cycle while the result side does not stall and the sine/cosine unit is idle.
// Sine/cosine come from an iterative 18-step CORDIC run once per angle:
//   after reset and after each angle write the point channel stalls while
//   it runs.
// Reset clears all valid bits and loads the register defaults.
// A result stall while result_valid is high freezes the whole pipeline;
//   point_stall rises at once and nothing is dropped or repeated.
// ============================================================================
`default_nettype none

module camera_rotate_zoom_transform
    import crzt_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 8,
    parameter int ZOOM_FRAC_BITS  = 16
)(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    point_valid,
    output logic                   point_stall,
    input  wire point_t            point,
    output logic                   result_valid,
    input  wire                    result_stall,
    output result_t                result,
    input  wire                    cfg_we,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int HALF_W  = VIEW_W + COORD_FRAC_BITS - 1;
    localparam int DIFF_W  = ((HALF_W + 1 > COORD_W) ? HALF_W + 1 : COORD_W) + 1;
    localparam int NUM_W   = DIFF_W + ZOOM_FRAC_BITS;
    localparam int LO_W    = 24;
    localparam int HI_W    = LIFT_W - LO_W;
    localparam int PLO_W   = LO_W + 1 + TRIG_W;
    localparam int PHI_W   = HI_W + TRIG_W;
    localparam int PROD_W  = 66;
    localparam int RX_W    = PROD_W - 16;
    localparam int RX0_W   = DIFF_W + 2;
    localparam int MZ_W    = RX0_W + ZOOM_W + 1;
    localparam int SUM_W   = ((MZ_W > RX_W) ? MZ_W : RX_W) + 2;
    localparam int ZMIN_RAW = ((1 << ZOOM_FRAC_BITS) + 500) / 1000;
    localparam logic [ZOOM_W-1:0] ZMIN = ZOOM_W'((ZMIN_RAW > 0) ? ZMIN_RAW : 1);
    localparam logic signed [SUM_W-1:0] ZHALF = SUM_W'(64'sd1 <<< (ZOOM_FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] ZHALF_M1 = ZHALF - SUM_W'(1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [ZOOM_W-1:0]  zoom_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic        [VIEW_W-1:0]  vw_reg;
    logic        [VIEW_W-1:0]  vh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg  <= ZOOM_W'(65536);
            angle_reg <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            vw_reg    <= VIEW_W'(1);
            vh_reg    <= VIEW_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ZOOM:     zoom_reg  <= cfg_data[ZOOM_W-1:0];
                REG_ANGLE:    angle_reg <= cfg_data[ANGLE_W-1:0];
                REG_CENTER_X: cx_reg    <= cfg_data[COORD_W-1:0];
                REG_CENTER_Y: cy_reg    <= cfg_data[COORD_W-1:0];
                REG_VIEW_W:   vw_reg    <= cfg_data[VIEW_W-1:0];
                REG_VIEW_H:   vh_reg    <= cfg_data[VIEW_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamped zoom and half view size
    logic [ZOOM_W-1:0] zc;
    logic [VIEW_W-1:0] w_eff;
    logic [VIEW_W-1:0] h_eff;
    logic [HALF_W-1:0] hw;
    logic [HALF_W-1:0] hh;

    always_comb
    begin
        zc    = (zoom_reg < ZMIN) ? ZMIN : zoom_reg;
        w_eff = (vw_reg == '0) ? VIEW_W'(1) : vw_reg;
        h_eff = (vh_reg == '0) ? VIEW_W'(1) : vh_reg;
        hw    = HALF_W'(w_eff) << (COORD_FRAC_BITS - 1);
        hh    = HALF_W'(h_eff) << (COORD_FRAC_BITS - 1);
    end

    // ------------------------------------------------------------------
    // Sine/cosine unit: reduce angle, 18 CORDIC steps, quadrant map
    // ------------------------------------------------------------------
    trig_state_t               tstate_reg, tstate_next;
    logic signed [ANGLE_W-1:0] tang_reg,   tang_next;
    logic        [1:0]         tquad_reg,  tquad_next;
    logic        [STEP_W-1:0]  tstep_reg,  tstep_next;
    logic signed [CV_W-1:0]    tx_reg,     tx_next;
    logic signed [CV_W-1:0]    ty_reg,     ty_next;
    logic signed [CZ_W-1:0]    tz_reg,     tz_next;
    logic signed [TRIG_W-1:0]  cos_reg,    cos_next;
    logic signed [TRIG_W-1:0]  sin_reg,    sin_next;
    logic                      trig_busy;

    always_comb
    begin
        logic signed [ANGLE_W-1:0] rem;
        logic signed [CV_W-1:0]    xr;
        logic signed [CV_W-1:0]    yr;
        logic signed [TRIG_W-1:0]  cc;
        logic signed [TRIG_W-1:0]  ss;

        tstate_next = tstate_reg;
        tang_next   = tang_reg;
        tquad_next  = tquad_reg;
        tstep_next  = tstep_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        tz_next     = tz_reg;
        cos_next    = cos_reg;
        sin_next    = sin_reg;
        rem         = '0;
        xr = tx_reg + (tx_reg[CV_W-1] ? CV_W'(8191) : CV_W'(8192));
        yr = ty_reg + (ty_reg[CV_W-1] ? CV_W'(8191) : CV_W'(8192));
        cc = TRIG_W'(xr >>> 14);
        ss = TRIG_W'(yr >>> 14);

        unique case (tstate_reg)
            TRIG_IDLE:
            begin
            end
            TRIG_LOAD:
            begin
                tang_next   = angle_reg;
                tstate_next = TRIG_REDUCE;
            end
            TRIG_REDUCE:
            begin
                if (tang_reg < 0)
                begin
                    tang_next = tang_reg + FULL_TURN;
                end
                else if (tang_reg >= FULL_TURN)
                begin
                    tang_next = tang_reg - FULL_TURN;
                end
                else
                begin
                    if (tang_reg < QUARTER_TURN)
                    begin
                        tquad_next = 2'd0;
                        rem        = tang_reg;
                    end
                    else if (tang_reg < HALF_TURN)
                    begin
                        tquad_next = 2'd1;
                        rem        = tang_reg - QUARTER_TURN;
                    end
                    else if (tang_reg < THREE_QUARTER_TURN)
                    begin
                        tquad_next = 2'd2;
                        rem        = tang_reg - HALF_TURN;
                    end
                    else
                    begin
                        tquad_next = 2'd3;
                        rem        = tang_reg - THREE_QUARTER_TURN;
                    end
                    tz_next     = CZ_W'(rem) <<< 9;
                    tx_next     = CORDIC_X0;
                    ty_next     = '0;
                    tstep_next  = '0;
                    tstate_next = TRIG_ROTATE;
                end
            end
            TRIG_ROTATE:
            begin
                if (tz_reg >= 0)
                begin
                    tx_next = tx_reg - (ty_reg >>> tstep_reg);
                    ty_next = ty_reg + (tx_reg >>> tstep_reg);
                    tz_next = tz_reg - atan_step(tstep_reg);
                end
                else
                begin
                    tx_next = tx_reg + (ty_reg >>> tstep_reg);
                    ty_next = ty_reg - (tx_reg >>> tstep_reg);
                    tz_next = tz_reg + atan_step(tstep_reg);
                end
                tstep_next = tstep_reg + STEP_W'(1);
                if (tstep_reg == LAST_STEP)
                begin
                    tstate_next = TRIG_FINISH;
                end
            end
            TRIG_FINISH:
            begin
                case (tquad_reg)
                    2'd0:
                    begin
                        cos_next = cc;
                        sin_next = ss;
                    end
                    2'd1:
                    begin
                        cos_next = -ss;
                        sin_next = cc;
                    end
                    2'd2:
                    begin
                        cos_next = -cc;
                        sin_next = -ss;
                    end
                    default:
                    begin
                        cos_next = ss;
                        sin_next = -cc;
                    end
                endcase
                tstate_next = TRIG_IDLE;
            end
            default:
            begin
                tstate_next = TRIG_LOAD;
            end
        endcase

        // a new angle restarts the unit
        if (cfg_we && (cfg_index == REG_ANGLE))
        begin
            tstate_next = TRIG_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tstate_reg <= TRIG_LOAD;
            tstep_reg  <= '0;
        end
        else
        begin
            tstate_reg <= tstate_next;
            tstep_reg  <= tstep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tang_reg  <= tang_next;
        tquad_reg <= tquad_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        tz_reg    <= tz_next;
        cos_reg   <= cos_next;
        sin_reg   <= sin_next;
    end

    assign trig_busy = (tstate_reg != TRIG_IDLE);

    // ------------------------------------------------------------------
    // Pipeline control: whole pipe moves unless the result is held
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic adv;
    logic take;

    assign adv         = !(out_valid_reg && result_stall);
    assign point_stall = !adv || trig_busy || (cfg_we && (cfg_index == REG_ANGLE));
    assign take        = point_valid && !point_stall;

    // ------------------------------------------------------------------
    // P0: offsets from center (mode 0) or from half view (mode 1)
    // ------------------------------------------------------------------
    logic                     p0_v_reg;
    logic                     p0_mode_reg, p0_mode_next;
    logic signed [DIFF_W-1:0] p0_dx_reg,   p0_dx_next;
    logic signed [DIFF_W-1:0] p0_dy_reg,   p0_dy_next;

    always_comb
    begin
        logic signed [DIFF_W-1:0] ofs_x;
        logic signed [DIFF_W-1:0] ofs_y;
        logic signed [DIFF_W-1:0] px;
        logic signed [DIFF_W-1:0] py;

        px = DIFF_W'(point.in_x);
        py = DIFF_W'(point.in_y);
        if (point.mode)
        begin
            ofs_x = DIFF_W'({1'b0, hw});
            ofs_y = DIFF_W'({1'b0, hh});
        end
        else
        begin
            ofs_x = DIFF_W'(cx_reg);
            ofs_y = DIFF_W'(cy_reg);
        end
        p0_mode_next = point.mode;
        p0_dx_next   = px - ofs_x;
        p0_dy_next   = py - ofs_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p0_v_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_mode_reg <= p0_mode_next;
            p0_dx_reg   <= p0_dx_next;
            p0_dy_reg   <= p0_dy_next;
        end
    end

    // ------------------------------------------------------------------
    // Zoom divider: stage 0 builds the rounded numerator, stages 1..NUM_W
    // each resolve one quotient bit (restoring)
    // ------------------------------------------------------------------
    logic [NUM_W:0]            dv_reg;
    logic                      dmode_reg [NUM_W+1];
    logic                      dmode_next[NUM_W+1];
    logic signed [DIFF_W-1:0]  ddx_reg   [NUM_W+1];
    logic signed [DIFF_W-1:0]  ddx_next  [NUM_W+1];
    logic signed [DIFF_W-1:0]  ddy_reg   [NUM_W+1];
    logic signed [DIFF_W-1:0]  ddy_next  [NUM_W+1];
    logic [NUM_W-1:0]          nqx_reg   [NUM_W+1];
    logic [NUM_W-1:0]          nqx_next  [NUM_W+1];
    logic [NUM_W-1:0]          nqy_reg   [NUM_W+1];
    logic [NUM_W-1:0]          nqy_next  [NUM_W+1];
    logic [ZOOM_W-1:0]         remx_reg  [NUM_W+1];
    logic [ZOOM_W-1:0]         remx_next [NUM_W+1];
    logic [ZOOM_W-1:0]         remy_reg  [NUM_W+1];
    logic [ZOOM_W-1:0]         remy_next [NUM_W+1];

    always_comb
    begin
        logic [DIFF_W-1:0] mag_x;
        logic [DIFF_W-1:0] mag_y;
        logic [ZOOM_W:0]   trial_x;
        logic [ZOOM_W:0]   trial_y;
        logic [ZOOM_W:0]   zc_e;
        logic              ge_x;
        logic              ge_y;

        zc_e  = {1'b0, zc};
        mag_x = p0_dx_reg[DIFF_W-1] ? DIFF_W'(-p0_dx_reg) : DIFF_W'(p0_dx_reg);
        mag_y = p0_dy_reg[DIFF_W-1] ? DIFF_W'(-p0_dy_reg) : DIFF_W'(p0_dy_reg);

        dmode_next[0] = p0_mode_reg;
        ddx_next[0]   = p0_dx_reg;
        ddy_next[0]   = p0_dy_reg;
        nqx_next[0]   = (NUM_W'(mag_x) << ZOOM_FRAC_BITS) + NUM_W'(zc[ZOOM_W-1:1]);
        nqy_next[0]   = (NUM_W'(mag_y) << ZOOM_FRAC_BITS) + NUM_W'(zc[ZOOM_W-1:1]);
        remx_next[0]  = '0;
        remy_next[0]  = '0;

        for (int k = 1; k <= NUM_W; k++)
        begin
            trial_x = {remx_reg[k-1], nqx_reg[k-1][NUM_W-1]};
            trial_y = {remy_reg[k-1], nqy_reg[k-1][NUM_W-1]};
            ge_x    = (trial_x >= zc_e);
            ge_y    = (trial_y >= zc_e);
            remx_next[k] = ge_x ? ZOOM_W'(trial_x - zc_e) : trial_x[ZOOM_W-1:0];
            remy_next[k] = ge_y ? ZOOM_W'(trial_y - zc_e) : trial_y[ZOOM_W-1:0];
            nqx_next[k]  = {nqx_reg[k-1][NUM_W-2:0], ge_x};
            nqy_next[k]  = {nqy_reg[k-1][NUM_W-2:0], ge_y};
            dmode_next[k] = dmode_reg[k-1];
            ddx_next[k]   = ddx_reg[k-1];
            ddy_next[k]   = ddy_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg <= '0;
        end
        else if (adv)
        begin
            dv_reg <= {dv_reg[NUM_W-1:0], p0_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= NUM_W; k++)
            begin
                dmode_reg[k] <= dmode_next[k];
                ddx_reg[k]   <= ddx_next[k];
                ddy_reg[k]   <= ddy_next[k];
                nqx_reg[k]   <= nqx_next[k];
                nqy_reg[k]   <= nqy_next[k];
                remx_reg[k]  <= remx_next[k];
                remy_reg[k]  <= remy_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // R0: select lifted offsets (quotient with sign, or plain offset)
    // ------------------------------------------------------------------
    logic                     r0_v_reg;
    logic                     r0_mode_reg, r0_mode_next;
    logic signed [LIFT_W-1:0] r0_lx_reg,   r0_lx_next;
    logic signed [LIFT_W-1:0] r0_ly_reg,   r0_ly_next;

    always_comb
    begin
        logic [63:0]              qx;
        logic [63:0]              qy;
        logic signed [LIFT_W-1:0] mx;
        logic signed [LIFT_W-1:0] my;

        qx = 64'(nqx_reg[NUM_W]);
        qy = 64'(nqy_reg[NUM_W]);
        if (qx > INV_LIMIT)
        begin
            qx = INV_LIMIT;
        end
        if (qy > INV_LIMIT)
        begin
            qy = INV_LIMIT;
        end
        mx = qx[LIFT_W-1:0];
        my = qy[LIFT_W-1:0];
        r0_mode_next = dmode_reg[NUM_W];
        if (dmode_reg[NUM_W])
        begin
            r0_lx_next = ddx_reg[NUM_W][DIFF_W-1] ? -mx : mx;
            r0_ly_next = ddy_reg[NUM_W][DIFF_W-1] ? -my : my;
        end
        else
        begin
            r0_lx_next = LIFT_W'(ddx_reg[NUM_W]);
            r0_ly_next = LIFT_W'(ddy_reg[NUM_W]);
        end
    end

    // ------------------------------------------------------------------
    // R1: partial products of the rotation (offsets split in two halves)
    // ------------------------------------------------------------------
    logic                    r1_v_reg;
    logic                    r1_mode_reg;
    logic signed [PLO_W-1:0] r1_xc_lo_reg, r1_xc_lo_next;
    logic signed [PHI_W-1:0] r1_xc_hi_reg, r1_xc_hi_next;
    logic signed [PLO_W-1:0] r1_ys_lo_reg, r1_ys_lo_next;
    logic signed [PHI_W-1:0] r1_ys_hi_reg, r1_ys_hi_next;
    logic signed [PLO_W-1:0] r1_xs_lo_reg, r1_xs_lo_next;
    logic signed [PHI_W-1:0] r1_xs_hi_reg, r1_xs_hi_next;
    logic signed [PLO_W-1:0] r1_yc_lo_reg, r1_yc_lo_next;
    logic signed [PHI_W-1:0] r1_yc_hi_reg, r1_yc_hi_next;

    always_comb
    begin
        logic signed [LO_W:0]     xlo;
        logic signed [HI_W-1:0]   xhi;
        logic signed [LO_W:0]     ylo;
        logic signed [HI_W-1:0]   yhi;
        logic signed [TRIG_W-1:0] s_eff;

        xlo   = {1'b0, r0_lx_reg[LO_W-1:0]};
        xhi   = r0_lx_reg[LIFT_W-1:LO_W];
        ylo   = {1'b0, r0_ly_reg[LO_W-1:0]};
        yhi   = r0_ly_reg[LIFT_W-1:LO_W];
        // inverse rotation: same form with the sine negated
        s_eff = r0_mode_reg ? -sin_reg : sin_reg;
        r1_xc_lo_next = xlo * cos_reg;
        r1_xc_hi_next = xhi * cos_reg;
        r1_ys_lo_next = ylo * s_eff;
        r1_ys_hi_next = yhi * s_eff;
        r1_xs_lo_next = xlo * s_eff;
        r1_xs_hi_next = xhi * s_eff;
        r1_yc_lo_next = ylo * cos_reg;
        r1_yc_hi_next = yhi * cos_reg;
    end

    // ------------------------------------------------------------------
    // R2: full products
    // ------------------------------------------------------------------
    logic                     r2_v_reg;
    logic                     r2_mode_reg;
    logic signed [PROD_W-1:0] r2_xc_reg, r2_xc_next;
    logic signed [PROD_W-1:0] r2_ys_reg, r2_ys_next;
    logic signed [PROD_W-1:0] r2_xs_reg, r2_xs_next;
    logic signed [PROD_W-1:0] r2_yc_reg, r2_yc_next;

    always_comb
    begin
        r2_xc_next = (PROD_W'(r1_xc_hi_reg) <<< LO_W) + PROD_W'(r1_xc_lo_reg);
        r2_ys_next = (PROD_W'(r1_ys_hi_reg) <<< LO_W) + PROD_W'(r1_ys_lo_reg);
        r2_xs_next = (PROD_W'(r1_xs_hi_reg) <<< LO_W) + PROD_W'(r1_xs_lo_reg);
        r2_yc_next = (PROD_W'(r1_yc_hi_reg) <<< LO_W) + PROD_W'(r1_yc_lo_reg);
    end

    // ------------------------------------------------------------------
    // R3: rotation sums
    // ------------------------------------------------------------------
    logic                     r3_v_reg;
    logic                     r3_mode_reg;
    logic signed [PROD_W-1:0] r3_sx_reg, r3_sx_next;
    logic signed [PROD_W-1:0] r3_sy_reg, r3_sy_next;

    always_comb
    begin
        r3_sx_next = r2_xc_reg - r2_ys_reg;
        r3_sy_next = r2_xs_reg + r2_yc_reg;
    end

    // ------------------------------------------------------------------
    // R4: drop trig fraction, round half away from zero
    // ------------------------------------------------------------------
    logic                   r4_v_reg;
    logic                   r4_mode_reg;
    logic signed [RX_W-1:0] r4_rx_reg, r4_rx_next;
    logic signed [RX_W-1:0] r4_ry_reg, r4_ry_next;

    always_comb
    begin
        logic signed [PROD_W-1:0] ax;
        logic signed [PROD_W-1:0] ay;

        ax = r3_sx_reg + (r3_sx_reg[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768));
        ay = r3_sy_reg + (r3_sy_reg[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768));
        r4_rx_next = ax[PROD_W-1:16];
        r4_ry_next = ay[PROD_W-1:16];
    end

    // ------------------------------------------------------------------
    // R5: zoom multiply (used by mode 0)
    // ------------------------------------------------------------------
    logic                   r5_v_reg;
    logic                   r5_mode_reg;
    logic signed [RX_W-1:0] r5_rx_reg;
    logic signed [RX_W-1:0] r5_ry_reg;
    logic signed [MZ_W-1:0] r5_mx_reg, r5_mx_next;
    logic signed [MZ_W-1:0] r5_my_reg, r5_my_next;

    always_comb
    begin
        logic signed [RX0_W-1:0]  ax;
        logic signed [RX0_W-1:0]  ay;
        logic signed [ZOOM_W:0]   zs;

        ax = r4_rx_reg[RX0_W-1:0];
        ay = r4_ry_reg[RX0_W-1:0];
        zs = {1'b0, zc};
        r5_mx_next = ax * zs;
        r5_my_next = ay * zs;
    end

    // ------------------------------------------------------------------
    // Output stage: final offset, saturation
    // ------------------------------------------------------------------
    result_t res_reg, res_next;

    always_comb
    begin
        logic signed [SUM_W-1:0] ox;
        logic signed [SUM_W-1:0] oy;
        logic signed [SUM_W-1:0] tx;
        logic signed [SUM_W-1:0] ty;
        logic                    sat;

        tx = SUM_W'(r5_mx_reg);
        ty = SUM_W'(r5_my_reg);
        tx = tx + (tx[SUM_W-1] ? ZHALF_M1 : ZHALF);
        ty = ty + (ty[SUM_W-1] ? ZHALF_M1 : ZHALF);
        if (r5_mode_reg)
        begin
            ox = SUM_W'(cx_reg) + SUM_W'(r5_rx_reg);
            oy = SUM_W'(cy_reg) + SUM_W'(r5_ry_reg);
        end
        else
        begin
            ox = (tx >>> ZOOM_FRAC_BITS) + $signed(SUM_W'({1'b0, hw}));
            oy = (ty >>> ZOOM_FRAC_BITS) + $signed(SUM_W'({1'b0, hh}));
        end
        sat = 1'b0;
        if (ox > SUM_W'(COORD_MAX))
        begin
            ox  = SUM_W'(COORD_MAX);
            sat = 1'b1;
        end
        else if (ox < SUM_W'(COORD_MIN))
        begin
            ox  = SUM_W'(COORD_MIN);
            sat = 1'b1;
        end
        if (oy > SUM_W'(COORD_MAX))
        begin
            oy  = SUM_W'(COORD_MAX);
            sat = 1'b1;
        end
        else if (oy < SUM_W'(COORD_MIN))
        begin
            oy  = SUM_W'(COORD_MIN);
            sat = 1'b1;
        end
        res_next.out_x     = ox[COORD_W-1:0];
        res_next.out_y     = oy[COORD_W-1:0];
        res_next.saturated = sat;
    end

    // ------------------------------------------------------------------
    // Back-end valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_v_reg      <= 1'b0;
            r1_v_reg      <= 1'b0;
            r2_v_reg      <= 1'b0;
            r3_v_reg      <= 1'b0;
            r4_v_reg      <= 1'b0;
            r5_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r0_v_reg      <= dv_reg[NUM_W];
            r1_v_reg      <= r0_v_reg;
            r2_v_reg      <= r1_v_reg;
            r3_v_reg      <= r2_v_reg;
            r4_v_reg      <= r3_v_reg;
            r5_v_reg      <= r4_v_reg;
            out_valid_reg <= r5_v_reg;
        end
    end

    // Back-end payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_mode_reg  <= r0_mode_next;
            r0_lx_reg    <= r0_lx_next;
            r0_ly_reg    <= r0_ly_next;

            r1_mode_reg  <= r0_mode_reg;
            r1_xc_lo_reg <= r1_xc_lo_next;
            r1_xc_hi_reg <= r1_xc_hi_next;
            r1_ys_lo_reg <= r1_ys_lo_next;
            r1_ys_hi_reg <= r1_ys_hi_next;
            r1_xs_lo_reg <= r1_xs_lo_next;
            r1_xs_hi_reg <= r1_xs_hi_next;
            r1_yc_lo_reg <= r1_yc_lo_next;
            r1_yc_hi_reg <= r1_yc_hi_next;

            r2_mode_reg  <= r1_mode_reg;
            r2_xc_reg    <= r2_xc_next;
            r2_ys_reg    <= r2_ys_next;
            r2_xs_reg    <= r2_xs_next;
            r2_yc_reg    <= r2_yc_next;

            r3_mode_reg  <= r2_mode_reg;
            r3_sx_reg    <= r3_sx_next;
            r3_sy_reg    <= r3_sy_next;

            r4_mode_reg  <= r3_mode_reg;
            r4_rx_reg    <= r4_rx_next;
            r4_ry_reg    <= r4_ry_next;

            r5_mode_reg  <= r4_mode_reg;
            r5_rx_reg    <= r4_rx_reg;
            r5_ry_reg    <= r4_ry_reg;
            r5_mx_reg    <= r5_mx_next;
            r5_my_reg    <= r5_my_next;

            res_reg      <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire
